// ===== rtl/idt_pkg.sv =====
// ----------------------------------------------------------------------------
// idt_pkg
// Shared types and constants of the indent/dedent tracker: character codes,
// event kinds, sequencer states and the configuration register map.
// ----------------------------------------------------------------------------
`default_nettype none

package idt_pkg;

    // Character codes that matter at line start
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    // Configuration register map
    localparam int unsigned CFG_ADDR_W   = 3;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned TAB_W        = 4;
    localparam logic [TAB_W-1:0] TAB_RESET = 4'd4;
    localparam logic [CFG_ADDR_W-3:0] REG_TAB_WIDTH = '0;

    typedef enum logic [1:0] {
        EV_INDENT    = 2'd0,
        EV_DEDENT    = 2'd1,
        EV_BADINDENT = 2'd2,
        EV_OVERFLOW  = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_POP,
        ST_ERR
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/idt_stack_mem.sv =====
// ----------------------------------------------------------------------------
// idt_stack_mem
// Level stack storage: one write port, one registered read port. The base
// entry always reads as zero, even if written; the tracker never writes it.
// ----------------------------------------------------------------------------
`default_nettype none

module idt_stack_mem #(
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned ADDR_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the last read word until the next read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (rd_addr == '0) begin
                rd_data_reg <= '0;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/idt_cfg.sv =====
// ----------------------------------------------------------------------------
// idt_cfg
// APB register file of the tracker: holds the tab width.
// ----------------------------------------------------------------------------
`default_nettype none

module idt_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [idt_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [idt_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [idt_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output logic      [idt_pkg::TAB_W-1:0]        tab_width
);
    import idt_pkg::*;

    logic             sel_tab;
    logic [TAB_W-1:0] tab_width_reg;
    logic [TAB_W-1:0] tab_width_next;

    assign sel_tab = (paddr[CFG_ADDR_W-1:2] == REG_TAB_WIDTH);
    assign pready  = 1'b1;

    always_comb begin
        tab_width_next = tab_width_reg;
        if (psel && penable && pwrite && pready && sel_tab) begin
            tab_width_next = pwdata[TAB_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tab_width_reg <= TAB_RESET;
        end else begin
            tab_width_reg <= tab_width_next;
        end
    end

    assign prdata    = sel_tab ? CFG_DATA_W'(tab_width_reg) : '0;
    assign tab_width = tab_width_reg;

endmodule

`default_nettype wire

// ===== rtl/indent_dedent_tracker.sv =====
// ----------------------------------------------------------------------------
// indent_dedent_tracker
// Line-start indentation tracker: turns a character stream into INDENT,
// DEDENT and indentation error events using a stack of indent columns.
//
// Usage:
//   Input channel (s_*): one character word per handshake, s_char_code plus
//   s_is_end for the end-of-input marker. Output channel (m_*): one event
//   word per handshake; m_last_of_run marks the final event of a character.
//   APB port: register 0 is the tab width (4 bits, reset 4).
//
//   Spaces, tabs, blank lines and mid-line characters produce no word and go
//   at one per cycle while the output register is free. A deeper line start
//   produces INDENT (or depth overflow) visible the cycle after acceptance; the
//   character rate is then one per cycle as long as the receiver keeps up.
//   A shallower line start pops levels from the stack memory. Each pop waits
//   on the registered read of the next level, and a trailing inconsistency
//   error follows the last DEDENT from its own state; input is held off
//   meanwhile.
//   When the receiver stalls, the pending event word holds in the output
//   register and input is held off until it is taken.
//   Reset clears the line state, the stack pointer and the output valid flag;
//   the stack memory needs no clearing pass since the base level reads as
//   zero and only pushed levels are ever read back.
// ----------------------------------------------------------------------------
`default_nettype none

module indent_dedent_tracker #(
    parameter int unsigned STACK_DEPTH = 16,
    parameter int unsigned COLUMN_BITS = 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input character words
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_char_code,
    input  wire logic                           s_is_end,
    // output event words
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [1:0]                     m_event_kind,
    output logic      [7:0]                     m_indent_column,
    output logic                                m_last_of_run,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [idt_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [idt_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [idt_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready
);
    import idt_pkg::*;

    localparam int unsigned PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned SUM_W = COLUMN_BITS + 1;
    localparam int unsigned EXT_W = (COLUMN_BITS > 8) ? COLUMN_BITS : 8;
    localparam logic [PTR_W-1:0] TOP_FULL = PTR_W'(STACK_DEPTH - 1);
    localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

    logic [TAB_W-1:0] tab_width;

    // Sequencer and line state
    state_t                 state_reg, state_next;
    logic                   at_line_start_reg, at_line_start_next;
    logic [COLUMN_BITS-1:0] column_count_reg, column_count_next;
    logic [PTR_W-1:0]       stack_top_reg, stack_top_next;
    logic [COLUMN_BITS-1:0] top_val_reg, top_val_next;   // copy of level at stack_top

    // Output register
    logic        m_valid_reg, m_valid_next;
    event_kind_t m_event_kind_reg, m_event_kind_next;
    logic [7:0]  m_indent_column_reg, m_indent_column_next;
    logic        m_last_of_run_reg, m_last_of_run_next;

    // Stack memory port
    logic                   mem_wr_en;
    logic [PTR_W-1:0]       mem_wr_addr;
    logic                   mem_rd_en;
    logic [PTR_W-1:0]       mem_rd_addr;
    logic [COLUMN_BITS-1:0] mem_rd_data;

    logic                   out_free;
    logic                   accept;
    logic                   emit;
    event_kind_t            emit_kind;
    logic                   emit_last;
    logic [SUM_W-1:0]       col_sum;
    logic [SUM_W-1:0]       col_inc;
    logic [COLUMN_BITS-1:0] col_sat;
    logic [EXT_W-1:0]       col_ext;

    idt_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .tab_width(tab_width)
    );

    idt_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (COLUMN_BITS),
        .ADDR_W(PTR_W)
    ) u_stack (
        .aclk   (aclk),
        .wr_en  (mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(column_count_reg),
        .rd_en  (mem_rd_en),
        .rd_addr(mem_rd_addr),
        .rd_data(mem_rd_data)
    );

    // Output word slot is free when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_RUN) && out_free;
    assign accept   = s_valid && s_ready;

    // Saturating column increment: one for a space, tab_width for a tab
    assign col_inc = (s_char_code == CH_TAB) ? SUM_W'(tab_width) : SUM_W'(1);
    assign col_sum = {1'b0, column_count_reg} + col_inc;
    assign col_sat = col_sum[COLUMN_BITS] ? COL_MAX : col_sum[COLUMN_BITS-1:0];
    assign col_ext = EXT_W'(column_count_reg);

    always_comb begin
        state_next         = state_reg;
        at_line_start_next = at_line_start_reg;
        column_count_next  = column_count_reg;
        stack_top_next     = stack_top_reg;
        top_val_next       = top_val_reg;
        mem_wr_en          = 1'b0;
        mem_wr_addr        = stack_top_reg + PTR_W'(1);
        mem_rd_en          = 1'b0;
        mem_rd_addr        = stack_top_reg - PTR_W'(1);
        emit               = 1'b0;
        emit_kind          = EV_INDENT;
        emit_last          = 1'b1;

        case (state_reg)
            ST_RUN: begin
                if (accept) begin
                    if (!at_line_start_reg) begin
                        // mid-line: only a newline matters
                        if (!s_is_end && s_char_code == CH_NL) begin
                            at_line_start_next = 1'b1;
                            column_count_next  = '0;
                        end
                    end else if (!s_is_end &&
                                 (s_char_code == CH_SPACE || s_char_code == CH_TAB)) begin
                        column_count_next = col_sat;
                    end else if (!s_is_end &&
                                 (s_char_code == CH_NL || s_char_code == CH_CR)) begin
                        // blank line: restart the count
                        column_count_next = '0;
                    end else begin
                        at_line_start_next = 1'b0;
                        if (column_count_reg > top_val_reg) begin
                            emit = 1'b1;
                            if (stack_top_reg == TOP_FULL) begin
                                emit_kind = EV_OVERFLOW;
                            end else begin
                                emit_kind      = EV_INDENT;
                                mem_wr_en      = 1'b1;
                                stack_top_next = stack_top_reg + PTR_W'(1);
                                top_val_next   = column_count_reg;
                            end
                        end else if (column_count_reg < top_val_reg) begin
                            // fetch the level below and start popping
                            mem_rd_en      = 1'b1;
                            stack_top_next = stack_top_reg - PTR_W'(1);
                            state_next     = ST_POP;
                        end
                    end
                end
            end

            ST_POP: begin
                // mem_rd_data is the level now at stack_top
                if (out_free) begin
                    emit      = 1'b1;
                    emit_kind = EV_DEDENT;
                    if (mem_rd_data > column_count_reg) begin
                        emit_last      = 1'b0;
                        mem_rd_en      = 1'b1;
                        stack_top_next = stack_top_reg - PTR_W'(1);
                    end else if (mem_rd_data == column_count_reg) begin
                        top_val_next = mem_rd_data;
                        state_next   = ST_RUN;
                    end else begin
                        emit_last    = 1'b0;
                        top_val_next = mem_rd_data;
                        state_next   = ST_ERR;
                    end
                end
            end

            ST_ERR: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_kind  = EV_BADINDENT;
                    state_next = ST_RUN;
                end
            end

            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Load a new word or drop the taken one
    always_comb begin
        m_valid_next         = m_valid_reg;
        m_event_kind_next    = m_event_kind_reg;
        m_indent_column_next = m_indent_column_reg;
        m_last_of_run_next   = m_last_of_run_reg;
        if (emit) begin
            m_valid_next         = 1'b1;
            m_event_kind_next    = emit_kind;
            m_indent_column_next = col_ext[7:0];
            m_last_of_run_next   = emit_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_RUN;
            at_line_start_reg <= 1'b1;
            column_count_reg  <= '0;
            stack_top_reg     <= '0;
            top_val_reg       <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            at_line_start_reg <= at_line_start_next;
            column_count_reg  <= column_count_next;
            stack_top_reg     <= stack_top_next;
            top_val_reg       <= top_val_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_event_kind_reg    <= m_event_kind_next;
        m_indent_column_reg <= m_indent_column_next;
        m_last_of_run_reg   <= m_last_of_run_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_event_kind    = m_event_kind_reg;
    assign m_indent_column = m_indent_column_reg;
    assign m_last_of_run   = m_last_of_run_reg;

    // The cached top level is the base level whenever the stack is empty in the run state
    a_base_level_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && stack_top_reg == '0) |-> (top_val_reg == '0))
        else $error("top level cache nonzero at empty stack");

    // Overflow is only reported with the stack full
    a_overflow_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_kind_reg == EV_OVERFLOW) |-> (stack_top_reg == TOP_FULL))
        else $error("overflow reported below full depth");

    // A pending INDENT matches the freshly pushed level
    a_indent_pushed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_kind_reg == EV_INDENT)
            |-> (top_val_reg == column_count_reg && stack_top_reg != '0))
        else $error("INDENT without matching push");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indent/dedent tracker. A shadow tracker follows
// every accepted character word and queues the INDENT, DEDENT and error events
// it calls for. The events taken from the block are compared with that queue
// in order. The stimulus is a short directed opening, then a deep-nesting run
// up to stack overflow and a full unwind, then random source text under
// several tab widths. Random idle gaps fall on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import idt_pkg::*;

    localparam int unsigned DEPTH        = 16;
    localparam int unsigned COL_MAX      = 255;
    localparam int unsigned MAX_GAP      = 8;
    localparam int unsigned SETTLE_CYCLE = 40;   // longest pop run plus margin
    localparam int unsigned PHASE_CHARS  = 40;
    localparam logic [CFG_ADDR_W-3:0] REG_SPARE = 1'b1;

    // one expected event word
    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  column;
        logic        last;
    } event_word_t;

    // Shadow tracker: line state, level stack and the queue of events owed.
    class indent_scoreboard;
        logic [TAB_W-1:0] tab_width;
        bit               at_line_start;
        logic [7:0]       column;
        logic [7:0]       levels [DEPTH];
        int unsigned      top;
        event_word_t      owed_events [$];
        int unsigned      mismatches;
        int unsigned      kind_seen [4];

        function new();
            tab_width     = TAB_RESET;
            at_line_start = 1'b1;
            column        = '0;
            foreach (levels[i]) levels[i] = '0;
            top           = 0;
            mismatches    = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-3:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == REG_TAB_WIDTH) tab_width = data[TAB_W-1:0];
        endfunction

        function void owe(event_kind_t kind);
            owed_events.push_back('{kind, column, 1'b0});
        endfunction

        // Advance the shadow state by one accepted character word.
        function void note_char(logic [7:0] ch, logic is_end);
            int unsigned first;
            int unsigned sum;
            if (!at_line_start) begin
                if (!is_end && ch == CH_NL) begin
                    at_line_start = 1'b1;
                    column        = '0;
                end
                return;
            end
            if (!is_end) begin
                if (ch == CH_SPACE || ch == CH_TAB) begin
                    sum    = column + ((ch == CH_SPACE) ? 1 : tab_width);
                    column = 8'((sum > COL_MAX) ? COL_MAX : sum);
                    return;
                end
                if (ch == CH_NL || ch == CH_CR) begin
                    column = '0;
                    return;
                end
            end
            at_line_start = 1'b0;
            first = owed_events.size();
            if (column > levels[top]) begin
                if (top + 1 >= DEPTH) begin
                    owe(EV_OVERFLOW);
                end else begin
                    top++;
                    levels[top] = column;
                    owe(EV_INDENT);
                end
            end else if (column < levels[top]) begin
                while (top > 0 && levels[top] > column) begin
                    top--;
                    owe(EV_DEDENT);
                end
                if (levels[top] != column) owe(EV_BADINDENT);
            end
            if (owed_events.size() > first) owed_events[$].last = 1'b1;
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10) $display("[%0t] MISMATCH: %s", $realtime, what);
        endfunction

        // Compare one taken event word with the oldest owed one.
        function void check_event(logic [1:0] kind, logic [7:0] col, logic last);
            event_word_t want;
            if (owed_events.size() == 0) begin
                flag($sformatf("unexpected event kind=%0d col=%0d last=%0d", kind, col, last));
                return;
            end
            want = owed_events.pop_front();
            kind_seen[want.kind]++;
            if (kind !== want.kind || col !== want.column || last !== want.last)
                flag($sformatf("kind %0d/%0d col %0d/%0d last %0d/%0d (expected/actual)",
                               want.kind, kind, want.column, col, want.last, last));
        endfunction
    endclass

    // DUT signals; every input starts at a known value
    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_char_code = '0;
    logic                  s_is_end    = 1'b0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [1:0]            m_event_kind;
    logic [7:0]            m_indent_column;
    logic                  m_last_of_run;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr       = '0;
    logic [CFG_DATA_W-1:0] pwdata      = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    indent_scoreboard sb = new();
    bit               quiet = 1'b0;   // no idling on either side while set
    int unsigned      chars_sent = 0;
    int unsigned      settings_used = 0;

    indent_dedent_tracker uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_is_end       (s_is_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_indent_column(m_indent_column),
        .m_last_of_run  (m_last_of_run),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Event receiver: stall a random number of cycles per word, then take it.
    // Sample on the falling edge, where valid, ready and payload are settled
    // for the rising edge that completes the handshake.
    initial begin
        int unsigned stall;
        logic [1:0]  kind;
        logic [7:0]  col;
        logic        last;
        forever begin
            stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(negedge aclk); while (m_valid !== 1'b1);
            kind = m_event_kind;
            col  = m_indent_column;
            last = m_last_of_run;
            @(posedge aclk);
            sb.check_event(kind, col, last);
        end
    end

    // Send one character word: wait out a random gap, hold valid and payload
    // until ready, then log the word in the shadow tracker at the accepting
    // edge. Returns on that edge with valid still high.
    task automatic send_char(input logic [7:0] ch, input logic is_end);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= ch;
        s_is_end    <= is_end;
        do @(negedge aclk); while (s_ready !== 1'b1);
        @(posedge aclk);
        sb.note_char(ch, is_end);
        chars_sent++;
    endtask

    // Drop valid and wait until every owed event has been taken. With settle
    // set, also let the block finish any internal work before a register write.
    task automatic drain(input bit settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.owed_events.size() != 0) @(posedge aclk);
        if (settle) repeat (SETTLE_CYCLE) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the value
    // at the edge that closes the access cycle (pready is tied high).
    task automatic write_reg(input logic [CFG_ADDR_W-3:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.write_reg(index, data);
        if (index == REG_TAB_WIDTH) settings_used++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // let the bus idle before it is used again
        @(posedge aclk);
    endtask

    // Program the tab width; upper data bits are random and must be ignored.
    task automatic set_tab_width(input logic [TAB_W-1:0] tw);
        logic [CFG_DATA_W-1:0] data;
        data           = $urandom();
        data[TAB_W-1:0] = tw;
        write_reg(REG_TAB_WIDTH, data);
    endtask

    // One random line. Mostly well-formed: optional blank line, indentation
    // aimed at a deeper, equal, existing or inconsistent column, a first
    // character (sometimes the end marker), a short body and a newline.
    // The rest is noise heavy in whitespace and line breaks.
    task automatic emit_line();
        int unsigned pick;
        int unsigned target;
        int unsigned col;
        int unsigned tw;
        logic [7:0]  ch;
        logic        is_end;
        tw   = sb.tab_width;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 4))
                    0:       ch = CH_TAB;
                    1:       ch = CH_NL;
                    2:       ch = CH_CR;
                    3:       ch = CH_SPACE;
                    default: ch = 8'($urandom_range(0, 255));
                endcase
                send_char(ch, $urandom_range(0, 15) == 0);
            end
            send_char(CH_NL, 1'b0);
            return;
        end
        if (pick < 30) begin
            repeat ($urandom_range(0, 3)) send_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
            send_char($urandom_range(0, 1) ? CH_NL : CH_CR, 1'b0);
        end
        // pick the column the line is aimed at
        case ($urandom_range(0, 3))
            0:       target = (sb.levels[sb.top] < 30) ? sb.levels[sb.top] + $urandom_range(1, 6)
                                                       : sb.levels[$urandom_range(0, sb.top)];
            1:       target = sb.levels[sb.top];
            2:       target = sb.levels[$urandom_range(0, sb.top)];
            default: target = $urandom_range(0, sb.levels[sb.top] + 2);
        endcase
        col = 0;
        while (col < target) begin
            if (tw > 0 && col + tw <= target && $urandom_range(0, 1)) begin
                send_char(CH_TAB, 1'b0);
                col += tw;
            end else begin
                send_char(CH_SPACE, 1'b0);
                col++;
            end
            // a zero-width tab adds nothing; sprinkle a few in
            if (tw == 0 && $urandom_range(0, 3) == 0) send_char(CH_TAB, 1'b0);
        end
        if ($urandom_range(0, 9) == 0) begin
            send_char(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            do ch = 8'($urandom_range(0, 255));
            while (ch == CH_TAB || ch == CH_NL || ch == CH_CR || ch == CH_SPACE);
            send_char(ch, 1'b0);
        end
        repeat ($urandom_range(0, 4)) begin
            ch     = 8'($urandom_range(0, 255));
            is_end = ($urandom_range(0, 19) == 0);
            if (ch == CH_NL && !is_end) ch = CH_CR;   // keep the line open
            send_char(ch, is_end);
        end
        send_char(CH_NL, 1'b0);
    endtask

    // Random phase: program a tab width, then stream lines until the budget
    // is spent. With hold set, pause once midway until all events are in.
    task automatic random_phase(input logic [TAB_W-1:0] tw, input bit no_idle,
                                input bit hold);
        int unsigned start;
        bit          held;
        drain(1'b1);
        set_tab_width(tw);
        quiet = no_idle;
        start = chars_sent;
        held  = 1'b0;
        while (chars_sent < start + PHASE_CHARS) begin
            emit_line();
            if (hold && !held && chars_sent >= start + PHASE_CHARS / 2) begin
                drain(1'b0);
                held = 1'b1;
            end
        end
    endtask

    initial begin
        // hold reset, then release it on a rising edge
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening at the reset tab width of four.
        // two spaces then text: indent at column 2; a return and a mid-line
        // end marker carrying a newline code do not end the line
        send_char(CH_SPACE, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char("a", 1'b0);
        send_char(CH_CR, 1'b0);
        send_char(CH_NL, 1'b1);
        send_char(CH_NL, 1'b0);
        // blank line closed by a return, then one closed by a newline
        send_char(CH_CR, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char(CH_NL, 1'b0);
        // one tab: indent at column 4
        send_char(CH_TAB, 1'b0);
        send_char("c", 1'b0);
        send_char(CH_NL, 1'b0);
        // column 1: two dedents then an inconsistency error
        send_char(CH_SPACE, 1'b0);
        send_char("d", 1'b0);
        send_char(CH_NL, 1'b0);
        // extreme byte values at column 0: equal level, nothing emitted
        send_char(8'hFF, 1'b0);
        send_char(CH_NL, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(CH_NL, 1'b0);
        // end marker at line start acts as text, even with a space code
        send_char(CH_TAB, 1'b0);
        send_char(CH_SPACE, 1'b1);
        send_char(CH_NL, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(CH_NL, 1'b0);

        // Deep nesting at tab width 15: fill all levels, overflow with a
        // saturated column, then unwind every level to an off-grid column.
        drain(1'b1);
        write_reg(REG_SPARE, $urandom());   // unmapped register, must be ignored
        set_tab_width(4'd15);
        send_char("x", 1'b0);
        send_char(CH_NL, 1'b0);
        for (int k = 1; k < DEPTH; k++) begin
            // level k sits at column 15*(k/2) + 2*(k%2)
            repeat (k / 2) send_char(CH_TAB, 1'b0);
            repeat (2 * (k % 2)) send_char(CH_SPACE, 1'b0);
            send_char(8'($urandom_range(33, 126)), 1'b0);
            send_char(CH_NL, 1'b0);
        end
        repeat (18) send_char(CH_TAB, 1'b0);
        send_char("o", 1'b0);
        send_char(CH_NL, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char("u", 1'b0);
        send_char(CH_NL, 1'b0);

        // Random text under several tab widths, extremes included; two
        // phases run with no idling, one pauses midway to let results drain.
        random_phase(4'd0, 1'b0, 1'b0);
        random_phase(4'd1, 1'b1, 1'b0);
        random_phase(4'd8, 1'b0, 1'b1);
        random_phase(4'($urandom_range(9, 15)), 1'b0, 1'b0);
        random_phase(4'($urandom_range(0, 15)), 1'b1, 1'b0);
        random_phase(TAB_RESET, 1'b0, 1'b0);

        // wait for the last events, then let the block settle to catch stray words
        drain(1'b1);

        $display("Run covered %0d characters under %0d tab-width settings,",
                 chars_sent, settings_used);
        $display("events: %0d indent, %0d dedent, %0d inconsistent, %0d overflow; %0d mismatches",
                 sb.kind_seen[EV_INDENT], sb.kind_seen[EV_DEDENT],
                 sb.kind_seen[EV_BADINDENT], sb.kind_seen[EV_OVERFLOW], sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/idt_pkg.sv
rtl/idt_stack_mem.sv
rtl/idt_cfg.sv
rtl/indent_dedent_tracker.sv
bench/tb_top.sv
